>>> rtl/windowed_slope_rate_of_rise_top_assert.svh
// assertion macros shared by the checker
`ifndef WINDOWED_SLOPE_RATE_OF_RISE_TOP_ASSERT_SVH
`define WINDOWED_SLOPE_RATE_OF_RISE_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define WSRR_ASSERT_NOW(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define WSRR_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

>>> rtl/wsrr_pkg.sv
package wsrr_pkg;

    localparam int TIME_W     = 48;
    localparam int TEMP_W     = 22;
    localparam int WIN_W      = 20;
    localparam int X_W        = 20;
    localparam int RATE_W     = 32;
    localparam int SCALE_W    = 16;
    localparam int MS_PER_MIN = 60000;

    // datapath commands issued by the controller
    typedef struct packed {
        logic wr;
        logic clr;
        logic acc1;
        logic acc2;
        logic mul1;
        logic chk;
        logic mul2;
        logic num;
        logic mul3;
        logic div;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic bad;
    } stat_t;

    // width of the scaled dividend, which is also the number of division steps
    function automatic int quot_width(int depth);
        int cw;
        cw = $clog2(depth + 1);
        return X_W + TEMP_W + 2 * cw + 3 + SCALE_W;
    endfunction

endpackage

>>> rtl/windowed_slope_rate_of_rise_top.sv
// flow: each input transfer writes the sample, then sweeps the filled ram slots twice, runs
//   the arithmetic steps and a restoring divider of Q = wsrr_pkg::quot_width(SAMPLE_DEPTH)
//   steps (73 at the default depth); a not-ready fit skips the divide
// a new sample is taken only after the last result is loaded into the output register; the
//   two sample ram sweeps and the one-bit-per-cycle restoring divider set the spacing
// reset: asynchronous active low; clears ring pointer, fill count, window, fsm and output valid
module windowed_slope_rate_of_rise_top #(
    parameter int SAMPLE_DEPTH      = 32,
    parameter int DEFAULT_WINDOW_MS = 30000
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration: window length in ms, zero picks the default
    input  logic                                cfg_we,
    input  logic [wsrr_pkg::WIN_W-1:0]          cfg_wdata,
    // sample channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [wsrr_pkg::TIME_W-1:0]         sample_time_ms,
    input  logic signed [wsrr_pkg::TEMP_W-1:0]  temperature_mdeg,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                status,
    output logic signed [wsrr_pkg::RATE_W-1:0]  rise_rate
);

    localparam int AW        = $clog2(SAMPLE_DEPTH);
    localparam int DIV_STEPS = wsrr_pkg::quot_width(SAMPLE_DEPTH);

    wsrr_pkg::cmd_t  cmd;
    wsrr_pkg::stat_t stat;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;

    // sequencer: ring pointers, the two ram sweeps, the arithmetic steps and
    // the divider count; the output register holds a result until its transfer
    wsrr_ctrl #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .DIV_STEPS    (DIV_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .stat      (stat)
    );

    // sample ram, window test, exact sums, products, divider and rounding
    wsrr_dp #(
        .SAMPLE_DEPTH      (SAMPLE_DEPTH),
        .DEFAULT_WINDOW_MS (DEFAULT_WINDOW_MS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .sample_time_ms   (sample_time_ms),
        .temperature_mdeg (temperature_mdeg),
        .cmd              (cmd),
        .rd_addr          (rd_addr),
        .wr_addr          (wr_addr),
        .stat             (stat),
        .status           (status),
        .rise_rate        (rise_rate)
    );

endmodule

>>> rtl/wsrr_ctrl.sv
module wsrr_ctrl #(
    parameter int SAMPLE_DEPTH = 32,
    parameter int DIV_STEPS    = 73
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    output logic                            out_valid,
    input  logic                            out_stall,
    output wsrr_pkg::cmd_t                  cmd,
    output logic [$clog2(SAMPLE_DEPTH)-1:0] rd_addr,
    output logic [$clog2(SAMPLE_DEPTH)-1:0] wr_addr,
    input  wsrr_pkg::stat_t                 stat
);

    localparam int AW = $clog2(SAMPLE_DEPTH);
    localparam int CW = $clog2(SAMPLE_DEPTH + 1);
    localparam int DW = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        IDLE, SCAN1, SCAN2, MUL1, CHK, MUL2, NUM, MUL3, DIV, FIN
    } state_t;

    state_t          state_reg;
    logic [AW-1:0]   slot_reg;
    logic [CW-1:0]   fill_reg;
    logic [CW-1:0]   idx_reg;
    logic [DW-1:0]   div_cnt_reg;
    logic            out_valid_reg;
    logic            accept;
    logic            load_out;
    logic            scan_last;

    assign in_stall  = (state_reg != IDLE);
    assign accept    = in_valid && !in_stall;
    assign load_out  = (state_reg == FIN) && (!out_valid_reg || !out_stall);
    assign scan_last = (idx_reg == fill_reg);
    assign out_valid = out_valid_reg;
    assign wr_addr   = slot_reg;
    assign rd_addr   = (idx_reg < CW'(SAMPLE_DEPTH)) ? idx_reg[AW-1:0] : '0;

    // read data is registered, so it arrives in the cycle after its address
    always_comb
    begin
        cmd      = '0;
        cmd.wr   = accept;
        cmd.clr  = accept;
        cmd.acc1 = (state_reg == SCAN1) && (idx_reg != '0);
        cmd.acc2 = (state_reg == SCAN2) && (idx_reg != '0);
        cmd.mul1 = (state_reg == MUL1);
        cmd.chk  = (state_reg == CHK);
        cmd.mul2 = (state_reg == MUL2);
        cmd.num  = (state_reg == NUM);
        cmd.mul3 = (state_reg == MUL3);
        cmd.div  = (state_reg == DIV);
        cmd.fin  = load_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            slot_reg      <= '0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        slot_reg <= (slot_reg == AW'(SAMPLE_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                        if (fill_reg != CW'(SAMPLE_DEPTH))
                            fill_reg <= fill_reg + 1'b1;
                        idx_reg   <= '0;
                        state_reg <= SCAN1;
                    end
                end
                SCAN1:
                begin
                    if (scan_last)
                    begin
                        idx_reg   <= '0;
                        state_reg <= SCAN2;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                SCAN2:
                begin
                    if (scan_last)
                        state_reg <= MUL1;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                MUL1: state_reg <= CHK;
                CHK:  state_reg <= stat.bad ? FIN : MUL2;
                MUL2: state_reg <= NUM;
                NUM:  state_reg <= MUL3;
                MUL3:
                begin
                    div_cnt_reg <= '0;
                    state_reg   <= DIV;
                end
                DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DW'(DIV_STEPS - 1))
                        state_reg <= FIN;
                end
                FIN:
                begin
                    if (load_out)
                        state_reg <= IDLE;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

endmodule

>>> rtl/wsrr_dp.sv
module wsrr_dp #(
    parameter int SAMPLE_DEPTH      = 32,
    parameter int DEFAULT_WINDOW_MS = 30000
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wsrr_pkg::WIN_W-1:0]          cfg_wdata,
    input  logic [wsrr_pkg::TIME_W-1:0]         sample_time_ms,
    input  logic signed [wsrr_pkg::TEMP_W-1:0]  temperature_mdeg,
    input  wsrr_pkg::cmd_t                      cmd,
    input  logic [$clog2(SAMPLE_DEPTH)-1:0]     rd_addr,
    input  logic [$clog2(SAMPLE_DEPTH)-1:0]     wr_addr,
    output wsrr_pkg::stat_t                     stat,
    output logic                                status,
    output logic signed [wsrr_pkg::RATE_W-1:0]  rise_rate
);

    localparam int TW    = wsrr_pkg::TIME_W;
    localparam int YW    = wsrr_pkg::TEMP_W;
    localparam int XW    = wsrr_pkg::X_W;
    localparam int WW    = wsrr_pkg::WIN_W;
    localparam int CW    = $clog2(SAMPLE_DEPTH + 1);
    localparam int SX_W  = XW + CW;
    localparam int SXX_W = 2 * XW + CW;
    localparam int SY_W  = YW + CW;
    localparam int SXY_W = XW + 1 + YW + CW;
    localparam int DEN_W = 2 * XW + 2 * CW;
    localparam int NUM_W = XW + YW + 2 * CW + 3;
    localparam int P_W   = wsrr_pkg::quot_width(SAMPLE_DEPTH);

    logic [TW-1:0]        mem_time [SAMPLE_DEPTH];
    logic signed [YW-1:0] mem_temp [SAMPLE_DEPTH];

    logic [WW-1:0]           window_reg;
    logic [TW-1:0]           rd_time_reg;
    logic signed [YW-1:0]    rd_temp_reg;
    logic [TW-1:0]           now_reg;
    logic [WW-1:0]           win_reg;
    logic [TW-1:0]           first_reg;
    logic [CW-1:0]           n_reg;
    logic [SX_W-1:0]         sx_reg;
    logic [SXX_W-1:0]        sxx_reg;
    logic signed [SY_W-1:0]  sy_reg;
    logic signed [SXY_W-1:0] sxy_reg;
    logic [DEN_W-1:0]        nsxx_reg;
    logic [DEN_W-1:0]        sx2_reg;
    logic [DEN_W-1:0]        den_reg;
    logic                    bad_reg;
    logic signed [NUM_W-1:0] nsxy_reg;
    logic signed [NUM_W-1:0] sxsy_reg;
    logic                    neg_reg;
    logic [NUM_W-1:0]        a_reg;
    logic [P_W-1:0]          pq_reg;
    logic [DEN_W-1:0]        rem_reg;
    logic                    status_reg;
    logic [31:0]             rate_reg;

    logic [TW-1:0]             age;
    logic                      qual;
    logic [TW-1:0]             dt;
    logic [XW-1:0]             x;
    logic [2*XW-1:0]           xx;
    logic signed [XW:0]        xs;
    logic signed [XW+YW:0]     xy;
    logic [DEN_W-1:0]          nsxx_c;
    logic [DEN_W-1:0]          sx2_c;
    logic signed [NUM_W-1:0]   nsxy_c;
    logic signed [NUM_W-1:0]   sxsy_c;
    logic signed [NUM_W-1:0]   num_c;
    logic [P_W-1:0]            p_c;
    logic [DEN_W:0]            r2;
    logic                      ge;
    logic                      big;
    logic                      rnd;
    logic [34:0]               qr;
    logic [31:0]               mag;

    assign stat.bad = (n_reg < CW'(2)) || (nsxx_reg <= sx2_reg);

    // window test against the sample being processed
    assign age  = now_reg - rd_time_reg;
    assign qual = (rd_time_reg <= now_reg) && (age <= TW'(win_reg));
    assign dt   = rd_time_reg - first_reg;
    assign x    = dt[XW-1:0];
    assign xx   = x * x;
    assign xs   = $signed({1'b0, x});
    assign xy   = xs * rd_temp_reg;

    assign nsxx_c = n_reg * sxx_reg;
    assign sx2_c  = sx_reg * sx_reg;
    assign nsxy_c = $signed({1'b0, n_reg}) * sxy_reg;
    assign sxsy_c = $signed({1'b0, sx_reg}) * sy_reg;
    assign num_c  = nsxy_reg - sxsy_reg;
    assign p_c    = a_reg * P_W'(wsrr_pkg::MS_PER_MIN);

    // one restoring division step
    assign r2 = {rem_reg, pq_reg[P_W-1]};
    assign ge = (r2 >= {1'b0, den_reg});

    // rounding and saturation of the finished quotient
    assign big = (pq_reg > P_W'(64'h2_0000_0000));
    assign rnd = ({rem_reg, 1'b0} >= {1'b0, den_reg});
    assign qr  = pq_reg[34:0] + 35'(rnd);
    assign mag = qr[31:0];

    assign status    = status_reg;
    assign rise_rate = $signed(rate_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= '0;
        else if (cfg_we)
            window_reg <= cfg_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem_time[wr_addr] <= sample_time_ms;
            mem_temp[wr_addr] <= temperature_mdeg;
        end
        rd_time_reg <= mem_time[rd_addr];
        rd_temp_reg <= mem_temp[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr)
        begin
            now_reg   <= sample_time_ms;
            win_reg   <= (window_reg == '0) ? WW'(DEFAULT_WINDOW_MS) : window_reg;
            first_reg <= '1;
            n_reg     <= '0;
            sx_reg    <= '0;
            sxx_reg   <= '0;
            sy_reg    <= '0;
            sxy_reg   <= '0;
        end
        if (cmd.acc1 && qual && (rd_time_reg < first_reg))
            first_reg <= rd_time_reg;
        if (cmd.acc2 && qual)
        begin
            n_reg   <= n_reg + 1'b1;
            sx_reg  <= sx_reg + SX_W'(x);
            sxx_reg <= sxx_reg + SXX_W'(xx);
            sy_reg  <= sy_reg + SY_W'(rd_temp_reg);
            sxy_reg <= sxy_reg + SXY_W'(xy);
        end
        if (cmd.mul1)
        begin
            nsxx_reg <= nsxx_c;
            sx2_reg  <= sx2_c;
        end
        if (cmd.chk)
        begin
            bad_reg <= stat.bad;
            den_reg <= nsxx_reg - sx2_reg;
        end
        if (cmd.mul2)
        begin
            nsxy_reg <= nsxy_c;
            sxsy_reg <= sxsy_c;
        end
        if (cmd.num)
        begin
            neg_reg <= num_c[NUM_W-1];
            a_reg   <= num_c[NUM_W-1] ? NUM_W'(-num_c) : NUM_W'(num_c);
        end
        if (cmd.mul3)
        begin
            pq_reg  <= p_c;
            rem_reg <= '0;
        end
        if (cmd.div)
        begin
            rem_reg <= ge ? DEN_W'(r2 - {1'b0, den_reg}) : r2[DEN_W-1:0];
            pq_reg  <= {pq_reg[P_W-2:0], ge};
        end
        if (cmd.fin)
        begin
            priority if (bad_reg)
            begin
                status_reg <= 1'b1;
                rate_reg   <= '0;
            end
            else if (neg_reg)
            begin
                status_reg <= 1'b0;
                rate_reg   <= (big || qr >= 35'h0_8000_0000) ? 32'h8000_0000 : (~mag + 1'b1);
            end
            else
            begin
                status_reg <= 1'b0;
                rate_reg   <= (big || qr >= 35'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
            end
        end
    end

endmodule

>>> rtl/wsrr_checker.sv
`include "windowed_slope_rate_of_rise_top_assert.svh"

module wsrr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [47:0]        sample_time_ms,
    input logic signed [21:0] temperature_mdeg,
    input logic               out_valid,
    input logic               out_stall,
    input logic               status,
    input logic signed [31:0] rise_rate
);

    `WSRR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(status) && $stable(rise_rate), "stalled result changed")
    `WSRR_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall,
        $stable(sample_time_ms) && $stable(temperature_mdeg), "stalled sample changed")
    `WSRR_ASSERT_NOW(a_not_ready_zero, clk, rst_n, out_valid && status,
        rise_rate == 32'sd0, "not-ready result with nonzero rate")
    `WSRR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall,
        in_stall, "input taken again right after a transfer")
    `WSRR_ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_valid && !in_stall,
        !$rose(out_valid), "result appeared one cycle after input")

endmodule

bind windowed_slope_rate_of_rise_top wsrr_checker u_wsrr_checker (.*);
